// ===== rtl/dlp_pkg.sv =====
package dlp_pkg;

  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int VIdxW       = $clog2(MaxVertices);
  localparam int EIdxW       = $clog2(MaxEdges);
  localparam int VCntW       = VIdxW + 1;
  localparam int ECntW       = EIdxW + 1;
  localparam int DegW        = ECntW;
  localparam int PathW       = 10;
  localparam logic [PathW-1:0] PathMax = '1;

  // Input item codes.
  localparam logic ActLoad    = 1'b0;
  localparam logic ActCompute = 1'b1;

  // Configuration register byte offsets.
  localparam logic [2:0] RegVertexCount = 3'd0;

  typedef enum logic [3:0] {
    StIdle,
    StLoadWr,
    StScan,
    StPop,
    StVtxRd,
    StVtxGot,
    StLink,
    StEdgeRd,
    StEdgeUpd,
    StMaxScan,
    StFinish,
    StClear
  } state_t;

endpackage

// ===== rtl/dlp_ram.sv =====
module dlp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dag_longest_path.sv =====
// Longest path, in edges, through a directed graph by a topological walk.
// Input channel (in_valid / in_stall): a beat with in_action load adds the
// edge in_from_vertex -> in_to_vertex; a beat with in_action compute runs
// the walk and yields one result beat. Loads give no result.
// Result channel (out_valid / out_stall): out_longest_path and
// out_edge_dropped, which is set when any edge of the graph was dropped for
// a vertex outside 1..min(vertex_count, 1024) or for a full edge store.
// vertex_count is to be written over the APB port at byte address 0 only
// while idle; the block itself does not enforce this. A load reads the list
// head and in-degree, then writes them back with the new edge. A compute
// seeds the queue, processes each queued vertex and walks its edges, finds
// the maximum, then sweeps the in-degree, path-length and list-head
// memories clear; every step is bound by the single read port of each
// memory. After reset the same sweep runs with in_stall high. The result
// sits in an output register: the clearing sweep proceeds while the
// receiver stalls, and a later result waits until the register is free.
module dag_longest_path (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [10:0]                in_from_vertex,
  input  logic [10:0]                in_to_vertex,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dlp_pkg::PathW-1:0]  out_longest_path,
  output logic                       out_edge_dropped,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dlp_pkg::*;

  state_t             state_r, state_nxt;
  logic [VCntW-1:0]   vc_r;
  logic [VCntW-1:0]   cnt_r, cnt_nxt;
  logic               vld_r, vld_nxt;
  logic [VIdxW-1:0]   vidx_r, vidx_nxt;
  logic [PathW-1:0]   best_r, best_nxt;
  logic [VCntW-1:0]   qrp_r, qrp_nxt;
  logic [VCntW-1:0]   qwp_r, qwp_nxt;
  logic [ECntW-1:0]   ec_r, ec_nxt;
  logic               drop_r, drop_nxt;
  logic [PathW-1:0]   cand_r, cand_nxt;
  logic [ECntW-1:0]   link_r, link_nxt;
  logic [VIdxW-1:0]   to_r, to_nxt;
  logic [VIdxW-1:0]   from_r, from_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PathW-1:0]   out_path_r, out_path_nxt;
  logic               out_drop_r, out_drop_nxt;

  logic [VCntW-1:0]   n_live;
  logic               load_bad;

  // Memory ports.
  logic               deg_we, plen_we, lh_we, en_we, et_we, rq_we;
  logic [VIdxW-1:0]   deg_waddr, plen_waddr, lh_waddr, rq_waddr;
  logic [VIdxW-1:0]   deg_raddr, plen_raddr, lh_raddr, rq_raddr;
  logic [EIdxW-1:0]   e_waddr, e_raddr;
  logic [DegW-1:0]    deg_wdata, deg_rdata;
  logic [PathW-1:0]   plen_wdata, plen_rdata;
  logic [ECntW-1:0]   lh_wdata, lh_rdata, en_wdata, en_rdata;
  logic [VIdxW-1:0]   et_wdata, et_rdata, rq_wdata, rq_rdata;

  dlp_ram #(.Width(DegW), .Depth(MaxVertices)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata));
  dlp_ram #(.Width(PathW), .Depth(MaxVertices)) u_plen (
    .clk, .we(plen_we), .waddr(plen_waddr), .wdata(plen_wdata),
    .raddr(plen_raddr), .rdata(plen_rdata));
  dlp_ram #(.Width(ECntW), .Depth(MaxVertices)) u_lhead (
    .clk, .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
    .raddr(lh_raddr), .rdata(lh_rdata));
  dlp_ram #(.Width(ECntW), .Depth(MaxEdges)) u_enext (
    .clk, .we(en_we), .waddr(e_waddr), .wdata(en_wdata),
    .raddr(e_raddr), .rdata(en_rdata));
  dlp_ram #(.Width(VIdxW), .Depth(MaxEdges)) u_etgt (
    .clk, .we(et_we), .waddr(e_waddr), .wdata(et_wdata),
    .raddr(e_raddr), .rdata(et_rdata));
  dlp_ram #(.Width(VIdxW), .Depth(MaxVertices)) u_rq (
    .clk, .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
    .raddr(rq_raddr), .rdata(rq_rdata));

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegVertexCount[2]) ? {{(32-VCntW){1'b0}}, vc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VCntW'(1);
    end else if (psel && penable && pwrite && paddr[2] == RegVertexCount[2]) begin
      vc_r <= pwdata[VCntW-1:0];
    end
  end

  // Effective vertex count and edge admission check.
  assign n_live = (vc_r > VCntW'(MaxVertices)) ? VCntW'(MaxVertices) : vc_r;
  assign load_bad = (in_from_vertex == '0) || (in_from_vertex > n_live) ||
                    (in_to_vertex == '0) || (in_to_vertex > n_live) ||
                    (ec_r >= ECntW'(MaxEdges));

  assign in_stall         = (state_r != StIdle);
  assign out_valid        = out_valid_r;
  assign out_longest_path = out_path_r;
  assign out_edge_dropped = out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StClear;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      qrp_r       <= '0;
      qwp_r       <= '0;
      ec_r        <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      qrp_r       <= qrp_nxt;
      qwp_r       <= qwp_nxt;
      ec_r        <= ec_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vidx_r     <= vidx_nxt;
    best_r     <= best_nxt;
    cand_r     <= cand_nxt;
    link_r     <= link_nxt;
    to_r       <= to_nxt;
    from_r     <= from_nxt;
    out_path_r <= out_path_nxt;
    out_drop_r <= out_drop_nxt;
  end

  // Sequencer: loads, queue seeding, walk, maximum and clearing sweep.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = vld_r;
    vidx_nxt      = vidx_r;
    best_nxt      = best_r;
    qrp_nxt       = qrp_r;
    qwp_nxt       = qwp_r;
    ec_nxt        = ec_r;
    drop_nxt      = drop_r;
    cand_nxt      = cand_r;
    link_nxt      = link_r;
    to_nxt        = to_r;
    from_nxt      = from_r;
    out_path_nxt  = out_path_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r && out_stall;

    deg_we = 1'b0; deg_waddr = to_r; deg_wdata = '0; deg_raddr = to_r;
    plen_we = 1'b0; plen_waddr = to_r; plen_wdata = cand_r; plen_raddr = to_r;
    lh_we = 1'b0; lh_waddr = from_r; lh_wdata = '0; lh_raddr = from_r;
    en_we = 1'b0; et_we = 1'b0; e_waddr = ec_r[EIdxW-1:0];
    en_wdata = lh_rdata; et_wdata = to_r;
    e_raddr = link_r[EIdxW-1:0] - EIdxW'(1);
    rq_we = 1'b0; rq_waddr = qwp_r[VIdxW-1:0]; rq_wdata = to_r;
    rq_raddr = qrp_r[VIdxW-1:0];

    case (state_r)
      StIdle: begin
        lh_raddr  = VIdxW'(in_from_vertex - 11'd1);
        deg_raddr = VIdxW'(in_to_vertex - 11'd1);
        if (in_valid) begin
          if (in_action == ActCompute) begin
            cnt_nxt   = '0;
            vld_nxt   = 1'b0;
            state_nxt = StScan;
          end else if (load_bad) begin
            drop_nxt = 1'b1;
          end else begin
            from_nxt  = VIdxW'(in_from_vertex - 11'd1);
            to_nxt    = VIdxW'(in_to_vertex - 11'd1);
            state_nxt = StLoadWr;
          end
        end
      end
      StLoadWr: begin
        // Prepend the edge to the source list and count it at the target.
        et_we     = 1'b1;
        en_we     = 1'b1;
        lh_we     = 1'b1;
        lh_wdata  = ec_r + ECntW'(1);
        deg_we    = 1'b1;
        deg_wdata = deg_rdata + DegW'(1);
        ec_nxt    = ec_r + ECntW'(1);
        state_nxt = StIdle;
      end
      StScan: begin
        // Queue every vertex that starts with no incoming edge.
        deg_raddr = cnt_r[VIdxW-1:0];
        if (vld_r && deg_rdata == '0 && qwp_r < VCntW'(MaxVertices)) begin
          rq_we    = 1'b1;
          rq_wdata = vidx_r;
          qwp_nxt  = qwp_r + VCntW'(1);
        end
        if (cnt_r < n_live) begin
          vld_nxt  = 1'b1;
          vidx_nxt = cnt_r[VIdxW-1:0];
          cnt_nxt  = cnt_r + VCntW'(1);
        end else begin
          vld_nxt   = 1'b0;
          state_nxt = StPop;
        end
      end
      StPop: begin
        if (qrp_r == qwp_r) begin
          cnt_nxt   = '0;
          vld_nxt   = 1'b0;
          best_nxt  = '0;
          state_nxt = StMaxScan;
        end else begin
          qrp_nxt   = qrp_r + VCntW'(1);
          state_nxt = StVtxRd;
        end
      end
      StVtxRd: begin
        plen_raddr = rq_rdata;
        lh_raddr   = rq_rdata;
        state_nxt  = StVtxGot;
      end
      StVtxGot: begin
        cand_nxt  = (plen_rdata == PathMax) ? PathMax : plen_rdata + PathW'(1);
        link_nxt  = lh_rdata;
        state_nxt = StLink;
      end
      StLink: begin
        state_nxt = (link_r == '0) ? StPop : StEdgeRd;
      end
      StEdgeRd: begin
        to_nxt     = et_rdata;
        link_nxt   = en_rdata;
        plen_raddr = et_rdata;
        deg_raddr  = et_rdata;
        state_nxt  = StEdgeUpd;
      end
      StEdgeUpd: begin
        // Relax the successor and release it when its last edge is seen.
        if (cand_r > plen_rdata) begin
          plen_we = 1'b1;
        end
        if (deg_rdata != '0) begin
          deg_we    = 1'b1;
          deg_wdata = deg_rdata - DegW'(1);
          if (deg_rdata == DegW'(1) && qwp_r < VCntW'(MaxVertices)) begin
            rq_we   = 1'b1;
            qwp_nxt = qwp_r + VCntW'(1);
          end
        end
        state_nxt = StLink;
      end
      StMaxScan: begin
        plen_raddr = cnt_r[VIdxW-1:0];
        if (vld_r && plen_rdata > best_r) begin
          best_nxt = plen_rdata;
        end
        if (cnt_r < n_live) begin
          vld_nxt = 1'b1;
          cnt_nxt = cnt_r + VCntW'(1);
        end else begin
          vld_nxt   = 1'b0;
          state_nxt = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_path_nxt  = best_r;
          out_drop_nxt  = drop_r;
          qrp_nxt       = '0;
          qwp_nxt       = '0;
          ec_nxt        = '0;
          drop_nxt      = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = StClear;
        end
      end
      StClear: begin
        // Sweep the per-vertex memories back to their empty values.
        deg_we     = 1'b1;
        deg_waddr  = cnt_r[VIdxW-1:0];
        plen_we    = 1'b1;
        plen_waddr = cnt_r[VIdxW-1:0];
        plen_wdata = '0;
        lh_we      = 1'b1;
        lh_waddr   = cnt_r[VIdxW-1:0];
        cnt_nxt    = cnt_r + VCntW'(1);
        if (cnt_r[VIdxW-1:0] == '1) begin
          cnt_nxt   = '0;
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/dlp_chk.sv =====
module dlp_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_action,
  input logic out_valid,
  input logic out_stall
);
  import dlp_pkg::*;

  // A waiting result beat is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // Reset starts the clearing sweep, so no input is taken right after it.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted right after reset");

  // A compute beat closes the input until the walk and the clearing sweep are done.
  a_compute_lock: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ActCompute |=> in_stall)
    else $error("input taken during a walk");

  // Results are far apart: the sweep follows each one.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result beats back to back");

endmodule

bind dag_longest_path dlp_chk u_dlp_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_action, .out_valid, .out_stall);

// ===== bench/dlp_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts each path result
// and compares it with what the block returns.
module dlp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [10:0] in_from_vertex,
  input  logic [10:0] in_to_vertex,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_longest_path,
  input  logic        out_edge_dropped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import dlp_pkg::*;

  typedef struct packed {
    logic [9:0] longest;
    logic       dropped;
  } path_result_t;

  path_result_t result_q[$];

  // Model copy of the graph.
  logic [10:0] vcount;
  int          degree[MaxVertices];
  int          plen[MaxVertices];
  int          succ_from[$];
  int          succ_to[$];
  bit          dropped;

  function automatic int live_count();
    return (vcount > MaxVertices) ? MaxVertices : int'(vcount);
  endfunction

  // Adjacency lists are walked newest edge first, as the block links them.
  function automatic path_result_t walk_graph();
    path_result_t r;
    int           ready[$];
    int           n;
    int           t;
    int           cand;
    int           best;
    n = live_count();
    best = 0;
    for (int i = 0; i < n; i++) if (degree[i] == 0) ready = {ready, i};
    while (ready.size() > 0) begin
      t = ready.pop_front();
      cand = (plen[t] >= 1023) ? 1023 : plen[t] + 1;
      for (int e = succ_from.size() - 1; e >= 0; e--) begin
        if (succ_from[e] == t) begin
          if (cand > plen[succ_to[e]]) plen[succ_to[e]] = cand;
          if (degree[succ_to[e]] != 0) begin
            degree[succ_to[e]]--;
            if (degree[succ_to[e]] == 0) ready = {ready, succ_to[e]};
          end
        end
      end
    end
    for (int i = 0; i < n; i++) if (plen[i] > best) best = plen[i];
    r.longest = best[9:0];
    r.dropped = dropped;
    return r;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < MaxVertices; i++) begin
      degree[i] = 0;
      plen[i] = 0;
    end
    succ_from.delete();
    succ_to.delete();
    dropped = 0;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    path_result_t exp_r;
    int           n;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      vcount <= 11'd1;
      clear_graph();
      result_q.delete();
      fail_count <= 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready && paddr == RegVertexCount)
        vcount <= pwdata[10:0];
      // Input beats.
      if (in_valid && !in_stall) begin
        n = live_count();
        if (in_action == ActLoad) begin
          if (in_from_vertex == 0 || in_from_vertex > n || in_to_vertex == 0 ||
              in_to_vertex > n || succ_from.size() >= MaxEdges) begin
            dropped = 1;
          end else begin
            succ_from = {succ_from, int'(in_from_vertex) - 1};
            succ_to = {succ_to, int'(in_to_vertex) - 1};
            degree[int'(in_to_vertex) - 1]++;
          end
        end else begin
          result_q = {result_q, walk_graph()};
          clear_graph();
        end
      end
      // Result beats.
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: actual path %0d dropped %0b", $time,
                   out_longest_path, out_edge_dropped);
          errs = errs + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.longest !== out_longest_path) begin
            $display("%0t: longest_path expected %0d actual %0d", $time,
                     exp_r.longest, out_longest_path);
            errs = errs + 1;
          end
          if (exp_r.dropped !== out_edge_dropped) begin
            $display("%0t: edge_dropped expected %0b actual %0b", $time,
                     exp_r.dropped, out_edge_dropped);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== bench/tb_dag_longest_path.sv =====
`timescale 1ns / 100ps

module tb_dag_longest_path;
  import dlp_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [10:0] in_from_vertex;
  logic [10:0] in_to_vertex;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_longest_path;
  logic        out_edge_dropped;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          quiet;
  int          vcnt;

  dag_longest_path dut (.*);

  dlp_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls in random bursts until the quiet tail of the run.
  initial begin
    out_stall = 0;
    @(posedge rst_n);
    while (1) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Sends one beat and waits for its acceptance.
  task automatic send_beat(input logic act, input int src, input int dst);
    in_valid       <= 1;
    in_action      <= act;
    in_from_vertex <= src[10:0];
    in_to_vertex   <= dst[10:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int value);
    psel    <= 1;
    pwrite  <= 1;
    paddr   <= RegVertexCount;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    vcnt = (value > MaxVertices) ? MaxVertices : value;
  endtask

  function automatic int pick_vertex();
    if (vcnt == 0) return $urandom_range(0, 3);
    return $urandom_range(1, vcnt);
  endfunction

  // A random graph: mostly forward edges so chains form, some back edges.
  task automatic random_graph(input int edges);
    int a;
    int b;
    for (int i = 0; i < edges; i++) begin
      a = pick_vertex();
      b = pick_vertex();
      if ($urandom_range(0, 19) == 0) begin
        a = $urandom_range(0, 2047);
      end else if ($urandom_range(0, 4) != 0 && a > b) begin
        a = a ^ b;
        b = a ^ b;
        a = a ^ b;
      end
      send_beat(ActLoad, a, b);
    end
    send_beat(ActCompute, $urandom_range(0, 2047), $urandom_range(0, 2047));
  endtask

  initial begin
    int sizes[6];
    int v;
    sizes = '{1, 5, 16, 40, 1024, 2047};
    rst_n = 0; in_valid = 0; in_action = 0; in_from_vertex = 0; in_to_vertex = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    quiet = 0; vcnt = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: default single vertex, self loop, empty graph, drops.
    send_beat(ActCompute, 0, 0);
    send_beat(ActLoad, 1, 1);
    send_beat(ActLoad, 0, 1);
    send_beat(ActCompute, 2047, 2047);
    drain_results();
    write_vertex_count(0);
    send_beat(ActLoad, 1, 1);
    send_beat(ActCompute, 0, 0);
    drain_results();
    write_vertex_count(2047);
    send_beat(ActLoad, 1024, 1);
    send_beat(ActLoad, 1, 1024);
    send_beat(ActLoad, 1025, 3);
    send_beat(ActLoad, 2, 1);
    send_beat(ActLoad, 3, 2);
    send_beat(ActLoad, 2, 3);
    send_beat(ActCompute, 0, 0);
    drain_results();

    // A chain through every vertex, which reaches the largest path length.
    write_vertex_count(1024);
    for (int i = 1; i < 1024; i++) send_beat(ActLoad, i, i + 1);
    send_beat(ActCompute, 0, 0);
    drain_results();

    // Random graphs over several vertex counts; the sender pauses between.
    v = 0;
    while (v < 700) begin
      if (v % 200 == 0) begin
        drain_results();
        write_vertex_count(($urandom_range(0, 7) == 0) ? sizes[$urandom_range(0, 5)]
                                                       : $urandom_range(0, 24));
      end
      if (v > 600) quiet = 1;
      random_graph($urandom_range(0, 12));
      v = v + 8;
    end
    drain_results();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
